@@ hdl/config_record_checker_core_macros.svh @@
// assertion macros for the record checker core
// no dependencies; pulled in only by config_record_checker_core, which checks its own logic
`ifndef CONFIG_RECORD_CHECKER_CORE_MACROS_SVH
`define CONFIG_RECORD_CHECKER_CORE_MACROS_SVH

// same-cycle implication
`define CRC_CHK_ASSERT_NOW(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define CRC_CHK_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

@@ hdl/crc_chk_pkg.sv @@
// types, constants and the byte-wide crc step for the record checker
// no dependencies; used by the interfaces and every module
package crc_chk_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned COUNT_W  = 5;
   localparam int unsigned BRIGHT_W = 7;
   localparam int unsigned HELD_W   = 24;

   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

   localparam logic [COUNT_W-1:0] REC_SIZE  = 5'd16;
   localparam logic [COUNT_W-1:0] LAST_POS  = 5'd15;
   localparam logic [COUNT_W-1:0] CRC_SPAN  = 5'd12;
   localparam logic [COUNT_W-1:0] MAGIC_LEN = 5'd4;
   localparam logic [COUNT_W-1:0] VER_POS   = 5'd4;
   localparam logic [COUNT_W-1:0] PLEN_POS  = 5'd5;
   localparam logic [COUNT_W-1:0] BRT_POS   = 5'd6;
   localparam logic [COUNT_W-1:0] INV_POS   = 5'd7;

   localparam logic [BYTE_W-1:0] PAYLOAD_LEN    = 8'd2;
   localparam logic [BYTE_W-1:0] MAX_BRIGHT     = 8'd100;
   localparam logic [BYTE_W-1:0] MAX_INV        = 8'd1;
   localparam logic [BYTE_W-1:0] SCHEMA_DEFAULT = 8'd1;

   // 'E' 'H' 'B' '1'
   localparam logic [BYTE_W-1:0] MAGIC_BYTES [4] = '{8'h45, 8'h48, 8'h42, 8'h31};

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK     = 3'd0,
      STATUS_LENGTH = 3'd1,
      STATUS_MAGIC  = 3'd2,
      STATUS_HEADER = 3'd3,
      STATUS_RANGE  = 3'd4,
      STATUS_CRC    = 3'd5
   } status_type;

   typedef struct packed {
      logic restart;
      logic load_byte;
   } crc_ctl_type;

   // reflected crc-32, one byte, eight shift steps unrolled
   function automatic logic [31:0] crc_byte_next(input logic [31:0] crc,
                                                 input logic [BYTE_W-1:0] data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

@@ hdl/crc_chk_req_if.sv @@
// input word channel: one record byte and its last flag
// depends on crc_chk_pkg
interface crc_chk_req_if import crc_chk_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] record_byte;
   logic              last_byte;

   modport source (output valid, record_byte, last_byte, input ready);
   modport sink   (input valid, record_byte, last_byte, output ready);
endinterface

@@ hdl/crc_chk_rsp_if.sv @@
// result word channel: verdict and decoded settings of one record
// depends on crc_chk_pkg
interface crc_chk_rsp_if import crc_chk_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                record_ok;
   logic [STATUS_W-1:0] status;
   logic [BRIGHT_W-1:0] led_brightness;
   logic                pitch_inverted;

   modport source (output valid, record_ok, status, led_brightness, pitch_inverted,
                   input ready);
   modport sink   (input valid, record_ok, status, led_brightness, pitch_inverted,
                   output ready);
endinterface

@@ hdl/config_record_checker_core.sv @@
// settings record checker: 16-byte record in, one verdict word per record out
// result: the last word passes the input reg, then its verdict goes to the result reg
// throughput: one word per cycle; a last word waits only while an untaken result is held
// reset (synchronous): counters, flags and both valid bits cleared, crc preset, version reg 1
// depends on crc_chk_pkg, both channel interfaces, crc_chk_crc32 and the macro header
`include "config_record_checker_core_macros.svh"

module config_record_checker_core import crc_chk_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   crc_chk_req_if.sink       req_chan,
   crc_chk_rsp_if.source     rsp_chan,
   input  logic              csr_write_enable,
   input  logic [BYTE_W-1:0] csr_write_data
);

   // configuration
   logic [BYTE_W-1:0] schema_ff;

   // input register
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_last_ff;
   logic              take;
   logic              advance;
   logic              fire;

   // per-record state
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                magic_bad_ff, magic_bad_in;
   logic                header_bad_ff, header_bad_in;
   logic                range_bad_ff, range_bad_in;
   logic [BRIGHT_W-1:0] bright_ff, bright_in;
   logic                inv_ff, inv_in;
   logic [HELD_W-1:0]   held_crc_ff, held_crc_in;

   crc_ctl_type crc_ctl;
   logic [31:0] crc_value;
   status_type  status_now;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_ok_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [BRIGHT_W-1:0] rsp_bright_ff;
   logic                rsp_inv_ff;

   // a non-last word never needs the result register
   assign advance = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_chan.ready);
   assign fire    = advance;
   assign req_chan.ready = !in_valid_ff || advance;
   assign take    = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         schema_ff   <= SCHEMA_DEFAULT;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_write_enable) begin
            schema_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_byte_ff <= req_chan.record_byte;
         in_last_ff <= req_chan.last_byte;
      end
   end

   // crc covers positions 0..11; restart wins when a short record ends
   assign crc_ctl.restart   = fire && in_last_ff;
   assign crc_ctl.load_byte = fire && (count_ff < CRC_SPAN);

   crc_chk_crc32 u_crc (
      .clock     (clock),
      .reset     (reset),
      .ctl       (crc_ctl),
      .data      (in_byte_ff),
      .crc_value (crc_value)
   );

   always_comb begin
      count_in      = count_ff;
      magic_bad_in  = magic_bad_ff;
      header_bad_in = header_bad_ff;
      range_bad_in  = range_bad_ff;
      bright_in     = bright_ff;
      inv_in        = inv_ff;
      held_crc_in   = held_crc_ff;
      if (fire) begin
         if (in_last_ff) begin
            count_in      = '0;
            magic_bad_in  = 1'b0;
            header_bad_in = 1'b0;
            range_bad_in  = 1'b0;
            bright_in     = '0;
            inv_in        = 1'b0;
            held_crc_in   = '0;
         end else if (count_ff < REC_SIZE) begin
            count_in = count_ff + 5'd1;
            if (count_ff < MAGIC_LEN) begin
               if (in_byte_ff != MAGIC_BYTES[count_ff[1:0]]) begin
                  magic_bad_in = 1'b1;
               end
            end else if (count_ff == VER_POS) begin
               if (in_byte_ff != schema_ff) begin
                  header_bad_in = 1'b1;
               end
            end else if (count_ff == PLEN_POS) begin
               if (in_byte_ff != PAYLOAD_LEN) begin
                  header_bad_in = 1'b1;
               end
            end else if (count_ff == BRT_POS) begin
               if (in_byte_ff > MAX_BRIGHT) begin
                  range_bad_in = 1'b1;
               end
               bright_in = in_byte_ff[BRIGHT_W-1:0];
            end else if (count_ff == INV_POS) begin
               if (in_byte_ff > MAX_INV) begin
                  range_bad_in = 1'b1;
               end
               inv_in = in_byte_ff[0];
            end
            if (count_ff >= CRC_SPAN) begin
               held_crc_in = {held_crc_ff[HELD_W-BYTE_W-1:0], in_byte_ff};
            end
         end
      end
   end

   // only a final word at position 15 gets past the length check, so the
   // stored crc is the three held bytes plus the current one
   always_comb begin
      if (count_ff != LAST_POS) begin
         status_now = STATUS_LENGTH;
      end else if (magic_bad_ff) begin
         status_now = STATUS_MAGIC;
      end else if (header_bad_ff) begin
         status_now = STATUS_HEADER;
      end else if (range_bad_ff) begin
         status_now = STATUS_RANGE;
      end else if ((crc_value ^ CRC_ONES) != {held_crc_ff, in_byte_ff}) begin
         status_now = STATUS_CRC;
      end else begin
         status_now = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         magic_bad_ff  <= 1'b0;
         header_bad_ff <= 1'b0;
         range_bad_ff  <= 1'b0;
         bright_ff     <= '0;
         inv_ff        <= 1'b0;
         held_crc_ff   <= '0;
      end else begin
         count_ff      <= count_in;
         magic_bad_ff  <= magic_bad_in;
         header_bad_ff <= header_bad_in;
         range_bad_ff  <= range_bad_in;
         bright_ff     <= bright_in;
         inv_ff        <= inv_in;
         held_crc_ff   <= held_crc_in;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire && in_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && in_last_ff) begin
         rsp_ok_ff     <= (status_now == STATUS_OK);
         rsp_status_ff <= status_now;
         rsp_bright_ff <= (status_now == STATUS_OK) ? bright_ff : '0;
         rsp_inv_ff    <= (status_now == STATUS_OK) ? inv_ff : 1'b0;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.record_ok      = rsp_ok_ff;
   assign rsp_chan.status         = rsp_status_ff;
   assign rsp_chan.led_brightness = rsp_bright_ff;
   assign rsp_chan.pitch_inverted = rsp_inv_ff;

   `CRC_CHK_ASSERT_NOW(a_count_sat, clock, reset, 1'b1,
      count_ff <= REC_SIZE, "byte count past record size")
   `CRC_CHK_ASSERT_NOW(a_ok_status, clock, reset, rsp_valid_ff,
      rsp_ok_ff == (rsp_status_ff == STATUS_OK), "record_ok disagrees with status")
   `CRC_CHK_ASSERT_NOW(a_reject_zero, clock, reset, rsp_valid_ff && !rsp_ok_ff,
      rsp_bright_ff == '0 && !rsp_inv_ff, "rejected record carries settings")
   `CRC_CHK_ASSERT_NEXT(a_clear_after_last, clock, reset, fire && in_last_ff,
      count_ff == '0 && crc_value == CRC_ONES, "record state not cleared after last word")
   `CRC_CHK_ASSERT_NEXT(a_no_result_mid, clock, reset, !(fire && in_last_ff) && rsp_chan.ready,
      !rsp_valid_ff, "result appeared without a last word")

endmodule

@@ hdl/crc_chk_crc32.sv @@
// running crc-32 accumulator, one byte per cycle while load_byte is set
// depends on crc_chk_pkg
module crc_chk_crc32 import crc_chk_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  crc_ctl_type       ctl,
   input  logic [BYTE_W-1:0] data,
   output logic [31:0]       crc_value
);

   logic [31:0] crc_ff;
   logic [31:0] crc_in;

   always_comb begin
      crc_in = crc_ff;
      if (ctl.restart) begin
         crc_in = CRC_ONES;
      end else if (ctl.load_byte) begin
         crc_in = crc_byte_next(crc_ff, data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= CRC_ONES;
      end else begin
         crc_ff <= crc_in;
      end
   end

   assign crc_value = crc_ff;

endmodule
